// ----- rtl/core/seqdw_pkg.sv -----
`default_nettype none

package seqdw_pkg;

  // Item kinds carried in bit 0 of the slave-side tuser.
  localparam logic MODE_LOOKUP = 1'b0;
  localparam logic MODE_MARK   = 1'b1;

  // Stream word widths.
  localparam int unsigned S_TDATA_W = 24;
  localparam int unsigned S_TUSER_W = 2;
  localparam int unsigned M_TDATA_W = 8;

  // Bit positions inside the slave-side words.
  localparam int unsigned TUSER_MODE_BIT   = 0;
  localparam int unsigned TUSER_DEFRAG_BIT = 1;
  localparam int unsigned TDATA_CLEAR_BIT  = 16;

  // Commands from the controller to the bitmap memory.
  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wipe;
  } mem_ctl_t;

endpackage

`default_nettype wire

// ----- rtl/core/seqdw_bitmap_mem.sv -----
`default_nettype none

module seqdw_bitmap_mem #(
  parameter int unsigned ROW_W     = 7,
  parameter int unsigned WORD_BITS = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire seqdw_pkg::mem_ctl_t      ctl_i,
  input  wire logic [ROW_W-1:0]         rd_addr_i,
  input  wire logic [ROW_W-1:0]         wr_addr_i,
  input  wire logic [2*WORD_BITS-1:0]   wr_data_i,
  output logic      [2*WORD_BITS-1:0]   rd_data_o
);

  localparam int unsigned ROWS   = 1 << ROW_W;
  localparam int unsigned DATA_W = 2 * WORD_BITS;

  // Each row holds the defragment map in its upper half, the plain map below.
  logic [DATA_W-1:0] mem_q [ROWS];
  logic [DATA_W-1:0] rdata_q;
  logic [ROWS-1:0]   valid_q;
  logic              rvalid_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
    if (ctl_i.rd_en) begin
      rdata_q <= mem_q[rd_addr_i];
    end
  end

  // A row that has not been written since the last wipe reads as all clear.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
    end else begin
      if (ctl_i.wipe) begin
        valid_q <= '0;
      end else if (ctl_i.wr_en) begin
        valid_q[wr_addr_i] <= 1'b1;
      end
      if (ctl_i.rd_en) begin
        rvalid_q <= valid_q[rd_addr_i];
      end
    end
  end

  assign rd_data_o = rvalid_q ? rdata_q : '0;

endmodule

`default_nettype wire

// ----- rtl/core/seqdw_ctrl.sv -----
`default_nettype none

module seqdw_ctrl #(
  parameter int unsigned SEQ_BITS    = 16,
  parameter int unsigned WINDOW_SIZE = 4096,
  parameter int unsigned WORD_BITS   = 32,
  parameter int unsigned ROW_W       = 7
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     in_valid_i,
  output logic                          in_ready_o,
  input  wire logic                     in_mode_i,
  input  wire logic [15:0]              in_seq_i,
  input  wire logic                     in_defrag_i,
  input  wire logic                     in_clear_i,
  output logic                          out_valid_o,
  input  wire logic                     out_ready_i,
  output logic                          out_accept_o,
  output seqdw_pkg::mem_ctl_t           mem_ctl_o,
  output logic      [ROW_W-1:0]         mem_rd_addr_o,
  output logic      [ROW_W-1:0]         mem_wr_addr_o,
  output logic      [2*WORD_BITS-1:0]   mem_wr_data_o,
  input  wire logic [2*WORD_BITS-1:0]   mem_rd_data_i
);

  localparam int unsigned IDX_W  = $clog2(WINDOW_SIZE);
  localparam int unsigned COL_W  = $clog2(WORD_BITS);
  localparam int unsigned ROWS   = 1 << ROW_W;
  localparam int unsigned DATA_W = 2 * WORD_BITS;
  localparam logic [32:0] SEQ_MAX33 = (33'd1 << SEQ_BITS) - 33'd1;
  localparam logic [32:0] WIN33     = 33'(WINDOW_SIZE);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_LOOK = 5'b00010,
    S_CRD  = 5'b00100,
    S_CWR  = 5'b01000,
    S_PUSH = 5'b10000
  } state_e;

  state_e              state_q, state_d;
  logic                mode_q, mode_d;
  logic                defrag_q, defrag_d;
  logic                clear_q, clear_d;
  logic [SEQ_BITS-1:0] seq_q, seq_d;
  logic [IDX_W-1:0]    idx_q, idx_d;
  logic [SEQ_BITS-1:0] ref_q, ref_d;
  logic [IDX_W-1:0]    from_q, from_d;
  logic                wrap_q, wrap_d;
  logic [ROW_W-1:0]    row_q, row_d;
  logic [ROW_W:0]      steps_q, steps_d;
  logic                res_q, res_d;
  logic                out_valid_q;
  logic                out_acc_q;

  // Incoming number reduced to SEQ_BITS.
  logic [31:0]         seq_in_ext;
  logic [SEQ_BITS-1:0] seq_in;
  logic [IDX_W-1:0]    idx_in;

  // Window arithmetic on the held item.
  logic [SEQ_BITS-1:0] ref_eff;
  logic                seq_lt;
  logic [SEQ_BITS-1:0] seq_dist;
  logic [32:0]         dist33;
  logic                in_window;
  logic                far_jump;
  logic [31:0]         ref_ext;
  logic [IDX_W-1:0]    from_n;
  logic [IDX_W-1:0]    span_off;
  logic                full_turn;
  logic [ROW_W-1:0]    row_from, row_to;
  logic                wrap_n;
  logic [ROW_W:0]      steps_n;

  // Row update helpers.
  logic [COL_W:0]      bit_sel;
  logic [DATA_W-1:0]   mark_mask;
  logic [WORD_BITS-1:0] lo_mask, hi_mask, clr_mask;
  logic                lo_en, hi_en;

  logic                fin;
  logic                fin_val;
  logic                out_free;
  logic                out_load;
  logic                out_val;

  assign seq_in_ext = {16'b0, in_seq_i} & SEQ_MAX33[31:0];
  assign seq_in     = seq_in_ext[SEQ_BITS-1:0];
  assign idx_in     = seq_in_ext[IDX_W-1:0];

  assign ref_eff   = ((ref_q == '0) || clear_q) ? seq_q : ref_q;
  assign seq_lt    = seq_q < ref_eff;
  assign seq_dist  = ref_eff - seq_q - SEQ_BITS'(seq_lt);
  assign dist33    = 33'(seq_dist);
  assign in_window = dist33 < WIN33;
  assign far_jump  = (SEQ_MAX33 >= WIN33) && (dist33 <= (SEQ_MAX33 - WIN33));

  assign ref_ext   = 32'(ref_eff);
  assign from_n    = ref_ext[IDX_W-1:0] + IDX_W'(1);
  assign span_off  = idx_q - from_n;
  assign full_turn = &span_off;
  assign row_from  = from_n[IDX_W-1:COL_W];
  assign row_to    = idx_q[IDX_W-1:COL_W];
  // A range that starts and ends in one row but wraps round visits every row.
  assign wrap_n    = (row_from == row_to) && (from_n[COL_W-1:0] > idx_q[COL_W-1:0]);
  assign steps_n   = wrap_n ? (ROW_W+1)'(ROWS) : ({1'b0, row_to - row_from} + (ROW_W+1)'(1));

  assign bit_sel   = {defrag_q, idx_q[COL_W-1:0]};
  assign mark_mask = DATA_W'(1) << bit_sel;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      lo_mask[j] = COL_W'(j) >= from_q[COL_W-1:0];
      hi_mask[j] = COL_W'(j) <= idx_q[COL_W-1:0];
    end
  end

  assign lo_en = row_q == from_q[IDX_W-1:COL_W];
  assign hi_en = row_q == idx_q[IDX_W-1:COL_W];

  always_comb begin
    if (lo_en && hi_en) begin
      clr_mask = wrap_q ? (lo_mask | hi_mask) : (lo_mask & hi_mask);
    end else if (lo_en) begin
      clr_mask = lo_mask;
    end else if (hi_en) begin
      clr_mask = hi_mask;
    end else begin
      clr_mask = '1;
    end
  end

  assign out_free   = !out_valid_q || out_ready_i;
  assign in_ready_o = state_q == S_IDLE;

  always_comb begin
    state_d       = state_q;
    mode_d        = mode_q;
    defrag_d      = defrag_q;
    clear_d       = clear_q;
    seq_d         = seq_q;
    idx_d         = idx_q;
    ref_d         = ref_q;
    from_d        = from_q;
    wrap_d        = wrap_q;
    row_d         = row_q;
    steps_d       = steps_q;
    res_d         = res_q;
    mem_ctl_o     = '0;
    mem_rd_addr_o = idx_q[IDX_W-1:COL_W];
    mem_wr_addr_o = row_q;
    mem_wr_data_o = mem_rd_data_i;
    fin           = 1'b0;
    fin_val       = 1'b1;
    out_load      = 1'b0;
    out_val       = res_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          mode_d          = in_mode_i;
          defrag_d        = in_defrag_i;
          clear_d         = in_clear_i;
          seq_d           = seq_in;
          idx_d           = idx_in;
          mem_ctl_o.rd_en = 1'b1;
          mem_rd_addr_o   = idx_in[IDX_W-1:COL_W];
          state_d         = S_LOOK;
        end
      end
      S_LOOK: begin
        if (mode_q == seqdw_pkg::MODE_MARK) begin
          mem_ctl_o.wr_en = 1'b1;
          mem_wr_addr_o   = idx_q[IDX_W-1:COL_W];
          mem_wr_data_o   = mem_rd_data_i | mark_mask;
          state_d         = S_IDLE;
        end else if (in_window) begin
          // A clear request leaves the number at distance zero in a wiped map.
          ref_d          = ref_eff;
          mem_ctl_o.wipe = clear_q;
          fin            = 1'b1;
          fin_val        = clear_q || !mem_rd_data_i[bit_sel];
        end else if (far_jump || full_turn) begin
          ref_d          = seq_q;
          mem_ctl_o.wipe = 1'b1;
          fin            = 1'b1;
        end else begin
          ref_d   = seq_q;
          from_d  = from_n;
          wrap_d  = wrap_n;
          row_d   = row_from;
          steps_d = steps_n;
          state_d = S_CRD;
        end
      end
      S_CRD: begin
        mem_ctl_o.rd_en = 1'b1;
        mem_rd_addr_o   = row_q;
        state_d         = S_CWR;
      end
      S_CWR: begin
        mem_ctl_o.wr_en = 1'b1;
        mem_wr_addr_o   = row_q;
        mem_wr_data_o   = mem_rd_data_i & ~{clr_mask, clr_mask};
        if (steps_q == (ROW_W+1)'(1)) begin
          fin = 1'b1;
        end else begin
          row_d   = row_q + ROW_W'(1);
          steps_d = steps_q - (ROW_W+1)'(1);
          state_d = S_CRD;
        end
      end
      S_PUSH: begin
        if (out_free) begin
          out_load = 1'b1;
          out_val  = res_q;
          state_d  = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (fin) begin
      if (out_free) begin
        out_load = 1'b1;
        out_val  = fin_val;
        state_d  = S_IDLE;
      end else begin
        res_d   = fin_val;
        state_d = S_PUSH;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      ref_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      ref_q   <= ref_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q   <= mode_d;
    defrag_q <= defrag_d;
    clear_q  <= clear_d;
    seq_q    <= seq_d;
    idx_q    <= idx_d;
    from_q   <= from_d;
    wrap_q   <= wrap_d;
    row_q    <= row_d;
    steps_q  <= steps_d;
    res_q    <= res_d;
    if (out_load) begin
      out_acc_q <= out_val;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_accept_o = out_acc_q;

endmodule

`default_nettype wire

// ----- rtl/core/seq_dedup_window.sv -----
// A mark word reads its bitmap row when taken and writes it back in S_LOOK; a lookup inside
// the window, a clear request or a far jump loads its result in S_LOOK (S_PUSH if stalled).
// A lookup that advances the window passes S_CRD and S_CWR for each bitmap row it touches,
// up to ROWS rows, since each row takes one read and one write on the bitmap memory.
// A new word is taken only once the controller is back in S_IDLE with the last one done.
// Reset: asynchronous, active low; the row valid flags clear at once, so no clearing pass.
`default_nettype none

module seq_dedup_window #(
  // Number of bits kept per map; must be a power of two.
  parameter int unsigned WINDOW_SIZE = 4096,
  // Width of the sequence number space.
  parameter int unsigned SEQ_BITS    = 16
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              s_axis_tvalid_i,
  output logic                                   s_axis_tready_o,
  // From bit 0 up: seq_num [15:0], clear_first [16], zero fill [23:17].
  input  wire logic [seqdw_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  // From bit 0 up: mode [0], use_defrag [1].
  input  wire logic [seqdw_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  output logic                                   m_axis_tvalid_o,
  input  wire logic                              m_axis_tready_i,
  // From bit 0 up: accept [0], zero fill [7:1].
  output logic      [seqdw_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  // The maps are laid out in rows of WORD_BITS bits, with both maps of one row side by
  // side in a single memory word. There are never more than 128 rows, so each row can
  // carry a valid flag; a wipe simply drops all flags at once.
  localparam int unsigned IDX_W     = $clog2(WINDOW_SIZE);
  localparam int unsigned WORD_BITS = (WINDOW_SIZE / 128 > 8) ? WINDOW_SIZE / 128 : 8;
  localparam int unsigned COL_W     = $clog2(WORD_BITS);
  localparam int unsigned ROW_W     = IDX_W - COL_W;

  seqdw_pkg::mem_ctl_t      mem_ctl;
  logic [ROW_W-1:0]         mem_rd_addr;
  logic [ROW_W-1:0]         mem_wr_addr;
  logic [2*WORD_BITS-1:0]   mem_wr_data;
  logic [2*WORD_BITS-1:0]   mem_rd_data;
  logic                     accept_bit;

  // The controller holds the reference number, does the window arithmetic and sequences
  // the row reads and writes; the result waits in its output register, so the slave side
  // is free again once the memory work of a word is over and the output register is free.
  seqdw_ctrl #(
    .SEQ_BITS    (SEQ_BITS),
    .WINDOW_SIZE (WINDOW_SIZE),
    .WORD_BITS   (WORD_BITS),
    .ROW_W       (ROW_W)
  ) u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (s_axis_tvalid_i),
    .in_ready_o    (s_axis_tready_o),
    .in_mode_i     (s_axis_tuser_i[seqdw_pkg::TUSER_MODE_BIT]),
    .in_seq_i      (s_axis_tdata_i[15:0]),
    .in_defrag_i   (s_axis_tuser_i[seqdw_pkg::TUSER_DEFRAG_BIT]),
    .in_clear_i    (s_axis_tdata_i[seqdw_pkg::TDATA_CLEAR_BIT]),
    .out_valid_o   (m_axis_tvalid_o),
    .out_ready_i   (m_axis_tready_i),
    .out_accept_o  (accept_bit),
    .mem_ctl_o     (mem_ctl),
    .mem_rd_addr_o (mem_rd_addr),
    .mem_wr_addr_o (mem_wr_addr),
    .mem_wr_data_o (mem_wr_data),
    .mem_rd_data_i (mem_rd_data)
  );

  // Both seen-maps live in one synchronous memory with a registered read port.
  seqdw_bitmap_mem #(
    .ROW_W     (ROW_W),
    .WORD_BITS (WORD_BITS)
  ) u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .ctl_i     (mem_ctl),
    .rd_addr_i (mem_rd_addr),
    .wr_addr_i (mem_wr_addr),
    .wr_data_i (mem_wr_data),
    .rd_data_o (mem_rd_data)
  );

  // Only the accept flag is carried; the upper bits are zero fill.
  assign m_axis_tdata_o = {{(seqdw_pkg::M_TDATA_W-1){1'b0}}, accept_bit};

endmodule

`default_nettype wire

// ----- rtl/core/seqdw_checker.sv -----
`default_nettype none

module seqdw_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              s_axis_tvalid_i,
  input wire logic                              s_axis_tready_o,
  input wire logic [seqdw_pkg::S_TDATA_W-1:0]   s_axis_tdata_i,
  input wire logic [seqdw_pkg::S_TUSER_W-1:0]   s_axis_tuser_i,
  input wire logic                              m_axis_tvalid_o,
  input wire logic                              m_axis_tready_i,
  input wire logic [seqdw_pkg::M_TDATA_W-1:0]   m_axis_tdata_o
);

  logic in_acc;
  logic is_mark;
  logic is_clear_lookup;

  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign is_mark         = s_axis_tuser_i[seqdw_pkg::TUSER_MODE_BIT] == seqdw_pkg::MODE_MARK;
  assign is_clear_lookup = (s_axis_tuser_i[seqdw_pkg::TUSER_MODE_BIT] == seqdw_pkg::MODE_LOOKUP)
                           && s_axis_tdata_i[seqdw_pkg::TDATA_CLEAR_BIT];

  // One word at a time: the slave side closes while the memory works on a word.
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> !s_axis_tready_o)
    else $error("slave side still ready in the cycle after a word was taken");

  // A mark word never produces a result word.
  a_mark_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_mark && !m_axis_tvalid_o |=> !m_axis_tvalid_o)
    else $error("result word appeared after a mark word");

  // A lookup with a clear request is always accepted, via S_LOOK into the output.
  a_clear_accepts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && is_clear_lookup && !m_axis_tvalid_o |-> ##2 (m_axis_tvalid_o && m_axis_tdata_o[0]))
    else $error("lookup with clear request did not give an accept result in time");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result word changed or dropped while stalled");

endmodule

bind seq_dedup_window seqdw_checker u_seqdw_checker (.*);

`default_nettype wire
